/* rtl/bsg_pkg.sv */
// types and codes shared by the bounding sphere grow block
// no dependencies; compiled first
package bsg_pkg;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_MERGE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    OC_STARTED  = 2'd0,
    OC_KEPT     = 2'd1,
    OC_REPLACED = 2'd2,
    OC_GROWN    = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ_INIT,
    ST_SQ_MUL,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DECIDE,
    ST_MV_INIT,
    ST_MV_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_MOVE,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_SQ_INIT,
    OP_MUL_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DECIDE,
    OP_MV_INIT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MOVE,
    OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic move;
    logic root_zero;
  } status_t;

endpackage

/* rtl/bsg_in_if.sv */
// input channel: valid/ready transaction carrying one sphere and a command
// depends on nothing
interface bsg_in_if #(parameter int unsigned COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;
  logic [COORD_BITS-2:0]        in_radius;

  modport source (output valid, command, in_x, in_y, in_z, in_radius, input ready);
  modport sink   (input valid, command, in_x, in_y, in_z, in_radius, output ready);
endinterface

/* rtl/bsg_out_if.sv */
// output channel: valid/ready transaction carrying the bounding sphere
// depends on nothing
interface bsg_out_if #(parameter int unsigned COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic [COORD_BITS-2:0]        out_radius;
  logic [1:0]                   outcome;

  modport source (output valid, out_x, out_y, out_z, out_radius, outcome, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_radius, outcome, output ready);
endinterface

/* rtl/bsg_datapath.sv */
// datapath: sphere state, shift-add multiplier lanes, square root, dividers
// depends on bsg_pkg
module bsg_datapath #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bsg_pkg::ctl_t                ctl_i,
  output bsg_pkg::status_t             status_o,
  input  logic signed [COORD_BITS-1:0] in_x_i,
  input  logic signed [COORD_BITS-1:0] in_y_i,
  input  logic signed [COORD_BITS-1:0] in_z_i,
  input  logic [COORD_BITS-2:0]        in_radius_i,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic signed [COORD_BITS-1:0] out_z_o,
  output logic [COORD_BITS-2:0]        out_radius_o,
  output logic [1:0]                   outcome_o
);
  import bsg_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned W = C + 1;
  localparam int unsigned P = 2 * W;
  localparam int unsigned E = W + 2;

  // architectural sphere
  logic signed [C-1:0] ctr_q [3];
  logic [C-2:0]        rad_q;
  // item and pending result
  logic signed [C-1:0] itm_q [3];
  logic [C-2:0]        irad_q;
  logic signed [C-1:0] pnd_q [3];
  logic [C-2:0]        prad_q;
  logic [1:0]          poc_q;
  // lanes
  logic                neg_q [3];
  logic [W-1:0]        mag_q [3];
  logic [P-1:0]        mcd_q [3];
  logic [W-1:0]        mpl_q [3];
  logic [P-1:0]        acc_q [3];
  logic [W-1:0]        drem_q [3];
  logic [W-1:0]        quo_q [3];
  // square root
  logic [P-1:0]        sq_q;
  logic [W-1:0]        root_q;
  logic [E-1:0]        srem_q;
  logic [W-1:0]        grow_q;
  // output register
  logic signed [C-1:0] out_q [3];
  logic [C-2:0]        orad_q;
  logic [1:0]          oc_q;

  // difference per axis
  logic signed [C:0]   dif [3];
  always_comb begin
    dif[0] = {itm_q[0][C-1], itm_q[0]} - {ctr_q[0][C-1], ctr_q[0]};
    dif[1] = {itm_q[1][C-1], itm_q[1]} - {ctr_q[1][C-1], ctr_q[1]};
    dif[2] = {itm_q[2][C-1], itm_q[2]} - {ctr_q[2][C-1], ctr_q[2]};
  end

  // square root digit step
  logic [E+1:0] st, trial;
  logic         sge;
  always_comb begin
    st    = {srem_q, sq_q[P-1:P-2]};
    trial = (E+2)'({root_q, 2'b01});
    sge   = (st >= trial);
  end

  // decision on the finished distance
  logic [E-1:0] dd, r1e, r2e, sum, rn, growth;
  logic [C-2:0] rn_sat;
  logic         kept, repl;
  always_comb begin
    dd     = E'(root_q);
    r1e    = E'(rad_q);
    r2e    = E'(irad_q);
    kept   = (r1e > dd + r2e);
    repl   = (r2e > dd + r1e);
    sum    = dd + r1e + r2e;
    rn     = sum >> 1;
    growth = (rn > r1e) ? rn - r1e : '0;
    rn_sat = (rn > E'({(C-1){1'b1}})) ? {(C-1){1'b1}} : rn[C-2:0];
  end

  assign status_o.move      = !kept && !repl && (root_q != '0) && (growth != '0);
  assign status_o.root_zero = (root_q == '0);

  // divider steps and moved centres
  logic [W:0]          dt [3];
  logic                dge [3];
  logic signed [C+1:0] mv [3];
  logic signed [C-1:0] mv_sat [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dt[i]  = {drem_q[i], acc_q[i][W-1]};
      dge[i] = (dt[i] >= {1'b0, root_q});
      mv[i]  = neg_q[i] ? {{2{ctr_q[i][C-1]}}, ctr_q[i]} - {1'b0, quo_q[i]}
                        : {{2{ctr_q[i][C-1]}}, ctr_q[i]} + {1'b0, quo_q[i]};
      if (mv[i][C+1:C-1] == 3'b000 || mv[i][C+1:C-1] == 3'b111) begin
        mv_sat[i] = mv[i][C-1:0];
      end else if (mv[i][C+1]) begin
        mv_sat[i] = {1'b1, {(C-1){1'b0}}};
      end else begin
        mv_sat[i] = {1'b0, {(C-1){1'b1}}};
      end
    end
  end

  // architectural state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) ctr_q[i] <= '0;
      rad_q <= '0;
    end else if (ctl_i.out_load) begin
      for (int i = 0; i < 3; i++) ctr_q[i] <= pnd_q[i];
      rad_q <= prad_q;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        itm_q[0] <= in_x_i;
        itm_q[1] <= in_y_i;
        itm_q[2] <= in_z_i;
        irad_q   <= in_radius_i;
        pnd_q[0] <= in_x_i;
        pnd_q[1] <= in_y_i;
        pnd_q[2] <= in_z_i;
        prad_q   <= in_radius_i;
        poc_q    <= OC_STARTED;
      end
      OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= dif[i][C];
          mag_q[i] <= dif[i][C] ? W'(-dif[i]) : W'(dif[i]);
        end
      end
      OP_SQ_INIT: begin
        for (int i = 0; i < 3; i++) begin
          mcd_q[i] <= P'(mag_q[i]);
          mpl_q[i] <= mag_q[i];
          acc_q[i] <= '0;
        end
      end
      OP_MV_INIT: begin
        for (int i = 0; i < 3; i++) begin
          mcd_q[i] <= P'(mag_q[i]);
          mpl_q[i] <= grow_q;
          acc_q[i] <= '0;
        end
      end
      OP_MUL_STEP: begin
        for (int i = 0; i < 3; i++) begin
          if (mpl_q[i][0]) acc_q[i] <= acc_q[i] + mcd_q[i];
          mcd_q[i] <= mcd_q[i] << 1;
          mpl_q[i] <= mpl_q[i] >> 1;
        end
      end
      OP_SQRT_INIT: begin
        sq_q   <= acc_q[0] + acc_q[1] + acc_q[2];
        root_q <= '0;
        srem_q <= '0;
      end
      OP_SQRT_STEP: begin
        sq_q   <= sq_q << 2;
        root_q <= {root_q[W-2:0], sge};
        srem_q <= sge ? E'(st - trial) : E'(st);
      end
      OP_DECIDE: begin
        grow_q <= growth[W-1:0];
        if (kept) begin
          for (int i = 0; i < 3; i++) pnd_q[i] <= ctr_q[i];
          prad_q <= rad_q;
          poc_q  <= OC_KEPT;
        end else if (repl) begin
          for (int i = 0; i < 3; i++) pnd_q[i] <= itm_q[i];
          prad_q <= irad_q;
          poc_q  <= OC_REPLACED;
        end else begin
          for (int i = 0; i < 3; i++) pnd_q[i] <= ctr_q[i];
          prad_q <= rn_sat;
          poc_q  <= OC_GROWN;
        end
      end
      OP_DIV_INIT: begin
        // quotient fits w bits, so the upper half is already below the divisor
        for (int i = 0; i < 3; i++) begin
          drem_q[i] <= acc_q[i][P-1:W];
          quo_q[i]  <= '0;
        end
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < 3; i++) begin
          drem_q[i] <= dge[i] ? W'(dt[i] - {1'b0, root_q}) : dt[i][W-1:0];
          quo_q[i]  <= {quo_q[i][W-2:0], dge[i]};
          acc_q[i]  <= acc_q[i] << 1;
        end
      end
      OP_MOVE: begin
        for (int i = 0; i < 3; i++) pnd_q[i] <= mv_sat[i];
      end
      default: begin
      end
    endcase
    if (ctl_i.out_load) begin
      for (int i = 0; i < 3; i++) out_q[i] <= pnd_q[i];
      orad_q <= prad_q;
      oc_q   <= poc_q;
    end
  end

  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign out_radius_o = orad_q;
  assign outcome_o    = oc_q;

endmodule

/* rtl/bsg_ctrl.sv */
// controller: sequences one item through the datapath, owns the handshakes
// depends on bsg_pkg
module bsg_ctrl #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_command_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bsg_pkg::status_t status_i,
  output bsg_pkg::ctl_t    ctl_o
);
  import bsg_pkg::*;

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned CW = $clog2(W);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ov_q, ov_d;
  logic          last;

  assign last = (cnt_q == CW'(W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = '0;
    ov_d         = ov_q && !out_ready_i;
    ctl_o.op     = OP_NONE;
    ctl_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          state_d  = (in_command_i == CMD_START) ? ST_FINISH : ST_DIFF;
        end
      end
      ST_DIFF: begin
        ctl_o.op = OP_DIFF;
        state_d  = ST_SQ_INIT;
      end
      ST_SQ_INIT: begin
        ctl_o.op = OP_SQ_INIT;
        state_d  = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        ctl_o.op = OP_MUL_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: begin
        ctl_o.op = OP_SQRT_INIT;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        ctl_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ctl_o.op = OP_DECIDE;
        state_d  = (status_i.move && !status_i.root_zero) ? ST_MV_INIT : ST_FINISH;
      end
      ST_MV_INIT: begin
        ctl_o.op = OP_MV_INIT;
        state_d  = ST_MV_MUL;
      end
      ST_MV_MUL: begin
        ctl_o.op = OP_MUL_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        ctl_o.op = OP_DIV_INIT;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        ctl_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (last) begin
          cnt_d   = '0;
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        ctl_o.op = OP_MOVE;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to be free
        if (!ov_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

/* rtl/bounding_sphere_grow.sv */
// top level of the running bounding sphere block
// depends on bsg_pkg, bsg_in_if, bsg_out_if, bsg_ctrl, bsg_datapath
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | command, in_x, in_y, in_z, in_radius
//  out_o   | out | valid / ready | out_x, out_y, out_z, out_radius, outcome
//
// a start goes through the finish state into the output register
// a merge runs the difference, square, square root and decide states; when
// the centre moves (neither kept nor replaced, nonzero distance and growth)
// it also runs the move multiply, divide and move states; the cost is set by
// the one-bit-per-cycle multiplier, square root and divider loops
// reset clears the sphere to radius zero at the origin, no clearing pass
// a finished result sits in the output register while the next item is taken;
// a stalled output only holds the block when the next result is ready
module bounding_sphere_grow #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsg_in_if.sink     in_i,
  bsg_out_if.source  out_o
);
  import bsg_pkg::*;

  ctl_t    ctl;
  status_t status;

  // sequencer: walks difference, squares, root, decision, move
  bsg_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_i     (status),
    .ctl_o        (ctl)
  );

  // arithmetic and sphere state
  bsg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .status_o     (status),
    .in_x_i       (in_i.in_x),
    .in_y_i       (in_i.in_y),
    .in_z_i       (in_i.in_z),
    .in_radius_i  (in_i.in_radius),
    .out_x_o      (out_o.out_x),
    .out_y_o      (out_o.out_y),
    .out_z_o      (out_o.out_z),
    .out_radius_o (out_o.out_radius),
    .outcome_o    (out_o.outcome)
  );

endmodule
